// ----- hw/rtl/fpe_pkg.sv -----
// ----------------------------------------------------------------------------
// fpe_pkg
// Shared types, codes and digit-step helpers for the frustum plane extractor.
// ----------------------------------------------------------------------------
package fpe_pkg;

   typedef logic signed [31:0] fix_type;

   typedef enum logic [2:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_TOP    = 3'd2,
      PLANE_BOTTOM = 3'd3,
      PLANE_NEAR   = 3'd4,
      PLANE_FAR    = 3'd5
   } plane_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_SEL  = 2'd1,
      STAT_ZERO_LEN = 2'd2
   } status_type;

   localparam int unsigned NUM_PROJ_REGS = 8;

   // bad: selector out of range, neg: subtract the selected column,
   // near: drop column 3
   typedef struct packed {
      logic bad;
      logic neg;
      logic near;
   } ctl_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
   } rt_step_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] q;
   } dv_step_type;

   // one digit of a restoring square root
   function automatic rt_step_type rt_step(input logic [33:0] rem, input logic [31:0] root,
                                          input logic [1:0] dig);
      logic [35:0] cur;
      logic [35:0] trial;
      rt_step_type res;
      cur   = {rem, dig};
      trial = {2'b00, root, 2'b01};
      if (cur >= trial) begin
         res.rem  = 34'(cur - trial);
         res.root = {root[30:0], 1'b1};
      end else begin
         res.rem  = cur[33:0];
         res.root = {root[30:0], 1'b0};
      end
      return res;
   endfunction

   // one bit of a restoring divide, rem stays below len
   function automatic dv_step_type dv_step(input logic [31:0] rem, input logic [31:0] q,
                                          input logic nbit, input logic [31:0] len);
      logic [32:0] cur;
      dv_step_type res;
      cur = {rem, nbit};
      if (cur >= {1'b0, len}) begin
         res.rem = 32'(cur - {1'b0, len});
         res.q   = {q[30:0], 1'b1};
      end else begin
         res.rem = cur[31:0];
         res.q   = {q[30:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/frustum_plane_extract.sv -----
// ----------------------------------------------------------------------------
// frustum_plane_extract
// Builds one clip plane from view * projection and scales it to a unit normal.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_stall  | req_func, req_view_rX_cYY
//   rsp     | out | rsp_valid / rsp_stall  | rsp_plane_a..d, rsp_status
//   csr     | in  | csr_valid / csr_ready  | csr_index, csr_data
//
// one beat per cycle while the response is not stalled
// the latency is set by the 32-digit root and the 32-bit quotient, two digits
// per stage
// reset clears the stage valid bits and the projection registers
// each stage holds only while it is full and the one after it is held, so
// empty slots close up while the response is stalled
// ----------------------------------------------------------------------------
module frustum_plane_extract #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [63:0]         req_view_r0_c01,
   input  logic [63:0]         req_view_r0_c23,
   input  logic [63:0]         req_view_r1_c01,
   input  logic [63:0]         req_view_r1_c23,
   input  logic [63:0]         req_view_r2_c01,
   input  logic [63:0]         req_view_r2_c23,
   input  logic [63:0]         req_view_r3_c01,
   input  logic [63:0]         req_view_r3_c23,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fpe_pkg::fix_type    rsp_plane_a,
   output fpe_pkg::fix_type    rsp_plane_b,
   output fpe_pkg::fix_type    rsp_plane_c,
   output fpe_pkg::fix_type    rsp_plane_d,
   output logic [1:0]          rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_data
);
   import fpe_pkg::*;

   localparam int SQ_STG = 16;
   localparam int DV_STG = 16;
   localparam int S_MUL  = 1;
   localparam int S_DOT  = 2;
   localparam int S_TERM = 3;
   localparam int S_SQR  = 4;
   localparam int S_SUM  = 5;
   localparam int S_RT0  = 6;
   localparam int S_DSET = S_RT0 + SQ_STG;
   localparam int S_DV0  = S_DSET + 1;
   localparam int S_OUT  = S_DV0 + DV_STG;
   localparam int NST    = S_OUT;
   localparam int ND     = 33 + FRAC_BITS;
   localparam int HW     = ND - 32;

   localparam logic signed [65:0] DOT_MAX  = 66'sd2147483647;
   localparam logic signed [65:0] DOT_MIN  = -66'sd2147483648;
   localparam logic signed [65:0] DOT_HALF = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [33:0] T_MAX    = 34'sd2147483647;
   localparam logic signed [33:0] T_MIN    = -34'sd2147483648;

   function automatic fix_type dot_round(input logic signed [63:0] a, input logic signed [63:0] b,
                                         input logic signed [63:0] c, input logic signed [63:0] d);
      logic signed [65:0] s;
      logic signed [65:0] sh;
      s  = 66'(a) + 66'(b) + 66'(c) + 66'(d) + DOT_HALF;
      sh = s >>> FRAC_BITS;
      if (sh > DOT_MAX) begin
         return fix_type'(DOT_MAX[31:0]);
      end else if (sh < DOT_MIN) begin
         return fix_type'(DOT_MIN[31:0]);
      end
      return fix_type'(sh[31:0]);
   endfunction

   // configuration
   logic [63:0] proj_ff [NUM_PROJ_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_PROJ_REGS; r++) begin
            proj_ff[r] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         proj_ff[csr_index] <= csr_data;
      end
   end

   // stage valid bits and ready chain
   logic [NST:1]   st_v_ff;
   logic [NST+1:1] rdy;

   assign rdy[NST+1] = !rsp_stall;
   for (genvar gk = 1; gk <= NST; gk++) begin : g_rdy
      assign rdy[gk] = !st_v_ff[gk] || rdy[gk+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff <= '0;
      end else begin
         if (rdy[1]) begin
            st_v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NST; k++) begin
            if (rdy[k]) begin
               st_v_ff[k] <= st_v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !rdy[S_MUL];
   assign rsp_valid = st_v_ff[NST];

   // stage 1: decode and multiply
   fix_type vw [4][4];
   fix_type pj [4][4];
   logic [1:0] col;
   ctl_type ctl_in;

   always_comb begin
      vw[0][0] = fix_type'(req_view_r0_c01[31:0]);
      vw[0][1] = fix_type'(req_view_r0_c01[63:32]);
      vw[0][2] = fix_type'(req_view_r0_c23[31:0]);
      vw[0][3] = fix_type'(req_view_r0_c23[63:32]);
      vw[1][0] = fix_type'(req_view_r1_c01[31:0]);
      vw[1][1] = fix_type'(req_view_r1_c01[63:32]);
      vw[1][2] = fix_type'(req_view_r1_c23[31:0]);
      vw[1][3] = fix_type'(req_view_r1_c23[63:32]);
      vw[2][0] = fix_type'(req_view_r2_c01[31:0]);
      vw[2][1] = fix_type'(req_view_r2_c01[63:32]);
      vw[2][2] = fix_type'(req_view_r2_c23[31:0]);
      vw[2][3] = fix_type'(req_view_r2_c23[63:32]);
      vw[3][0] = fix_type'(req_view_r3_c01[31:0]);
      vw[3][1] = fix_type'(req_view_r3_c01[63:32]);
      vw[3][2] = fix_type'(req_view_r3_c23[31:0]);
      vw[3][3] = fix_type'(req_view_r3_c23[63:32]);
      for (int r = 0; r < 4; r++) begin
         pj[r][0] = fix_type'(proj_ff[2*r][31:0]);
         pj[r][1] = fix_type'(proj_ff[2*r][63:32]);
         pj[r][2] = fix_type'(proj_ff[2*r+1][31:0]);
         pj[r][3] = fix_type'(proj_ff[2*r+1][63:32]);
      end
   end

   always_comb begin
      col    = 2'd0;
      ctl_in = '0;
      unique case (req_func)
         PLANE_LEFT:   begin col = 2'd0; end
         PLANE_RIGHT:  begin col = 2'd0; ctl_in.neg = 1'b1; end
         PLANE_TOP:    begin col = 2'd1; ctl_in.neg = 1'b1; end
         PLANE_BOTTOM: begin col = 2'd1; end
         PLANE_NEAR:   begin col = 2'd2; ctl_in.near = 1'b1; end
         PLANE_FAR:    begin col = 2'd2; ctl_in.neg = 1'b1; end
         default:      begin ctl_in.bad = 1'b1; end
      endcase
   end

   logic signed [63:0] mu_p3_ff [4][4];
   logic signed [63:0] mu_pc_ff [4][4];
   ctl_type            mu_ctl_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_MUL]) begin
         for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
               mu_p3_ff[i][k] <= vw[i][k] * pj[k][3];
               mu_pc_ff[i][k] <= vw[i][k] * pj[k][col];
            end
         end
         mu_ctl_ff <= ctl_in;
      end
   end

   // stage 2: dot products with rounding
   fix_type dt_m3_ff [4];
   fix_type dt_mc_ff [4];
   ctl_type dt_ctl_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_DOT]) begin
         for (int i = 0; i < 4; i++) begin
            dt_m3_ff[i] <= dot_round(mu_p3_ff[i][0], mu_p3_ff[i][1],
                                     mu_p3_ff[i][2], mu_p3_ff[i][3]);
            dt_mc_ff[i] <= dot_round(mu_pc_ff[i][0], mu_pc_ff[i][1],
                                     mu_pc_ff[i][2], mu_pc_ff[i][3]);
         end
         dt_ctl_ff <= mu_ctl_ff;
      end
   end

   // stage 3: plane terms
   fix_type tm_in [4];
   fix_type tm_t_ff [4];
   ctl_type tm_ctl_ff;

   always_comb begin
      logic signed [33:0] a;
      logic signed [33:0] b;
      logic signed [33:0] s;
      for (int i = 0; i < 4; i++) begin
         a = dt_ctl_ff.near ? 34'sd0 : 34'(dt_m3_ff[i]);
         b = dt_ctl_ff.neg ? -34'(dt_mc_ff[i]) : 34'(dt_mc_ff[i]);
         s = a + b;
         if (s > T_MAX) begin
            tm_in[i] = fix_type'(T_MAX[31:0]);
         end else if (s < T_MIN) begin
            tm_in[i] = fix_type'(T_MIN[31:0]);
         end else begin
            tm_in[i] = fix_type'(s[31:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_TERM]) begin
         tm_t_ff   <= tm_in;
         tm_ctl_ff <= dt_ctl_ff;
      end
   end

   // stage 4: squares
   logic signed [63:0] sr_sq_ff [3];
   fix_type            sr_t_ff [4];
   ctl_type            sr_ctl_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_SQR]) begin
         for (int i = 0; i < 3; i++) begin
            sr_sq_ff[i] <= tm_t_ff[i] * tm_t_ff[i];
         end
         sr_t_ff   <= tm_t_ff;
         sr_ctl_ff <= tm_ctl_ff;
      end
   end

   // stage 5: sum of squares
   logic [63:0] su_n_ff;
   fix_type     su_t_ff [4];
   ctl_type     su_ctl_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_SUM]) begin
         su_n_ff   <= 64'(sr_sq_ff[0]) + 64'(sr_sq_ff[1]) + 64'(sr_sq_ff[2]);
         su_t_ff   <= sr_t_ff;
         su_ctl_ff <= sr_ctl_ff;
      end
   end

   // square root, two digits per stage
   logic [33:0] rt_rem_ff  [SQ_STG];
   logic [31:0] rt_root_ff [SQ_STG];
   logic [63:0] rt_n_ff    [SQ_STG];
   fix_type     rt_t_ff    [SQ_STG][4];
   ctl_type     rt_ctl_ff  [SQ_STG];

   for (genvar gs = 0; gs < SQ_STG; gs++) begin : g_rt
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] n_prev;
      rt_step_type st0;
      rt_step_type st1;

      if (gs == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign n_prev    = su_n_ff;
      end else begin : g_next
         assign rem_prev  = rt_rem_ff[gs-1];
         assign root_prev = rt_root_ff[gs-1];
         assign n_prev    = rt_n_ff[gs-1];
      end

      always_comb begin
         st0 = rt_step(rem_prev, root_prev, n_prev[2*(31-2*gs) +: 2]);
         st1 = rt_step(st0.rem, st0.root, n_prev[2*(30-2*gs) +: 2]);
      end

      always_ff @(posedge clock) begin
         if (rdy[S_RT0+gs]) begin
            rt_rem_ff[gs]  <= st1.rem;
            rt_root_ff[gs] <= st1.root;
            rt_n_ff[gs]    <= n_prev;
            if (gs == 0) begin
               rt_t_ff[gs]   <= su_t_ff;
               rt_ctl_ff[gs] <= su_ctl_ff;
            end else begin
               rt_t_ff[gs]   <= rt_t_ff[gs-1];
               rt_ctl_ff[gs] <= rt_ctl_ff[gs-1];
            end
         end
      end
   end

   // divide setup
   logic [31:0] ds_len;
   logic [31:0] ds_rem_in [4];
   logic [31:0] ds_lo_in  [4];
   logic [3:0]  ds_ovf_in;
   logic [3:0]  ds_neg_in;

   assign ds_len = rt_root_ff[SQ_STG-1];

   always_comb begin
      logic [32:0]   tn;
      logic [31:0]   mag;
      logic [ND-1:0] num;
      for (int l = 0; l < 4; l++) begin
         tn           = -33'(rt_t_ff[SQ_STG-1][l]);
         ds_neg_in[l] = rt_t_ff[SQ_STG-1][l][31];
         mag          = ds_neg_in[l] ? tn[31:0] : rt_t_ff[SQ_STG-1][l][31:0];
         num          = (ND'(mag) << FRAC_BITS) + ND'(ds_len >> 1);
         ds_rem_in[l] = {{(32-HW){1'b0}}, num[ND-1:32]};
         ds_lo_in[l]  = num[31:0];
         ds_ovf_in[l] = ds_rem_in[l] >= ds_len;
      end
   end

   logic [31:0] ds_rem_ff [4];
   logic [31:0] ds_lo_ff  [4];
   logic [3:0]  ds_ovf_ff;
   logic [3:0]  ds_neg_ff;
   logic [31:0] ds_len_ff;
   logic        ds_zero_ff;
   ctl_type     ds_ctl_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_DSET]) begin
         ds_rem_ff  <= ds_rem_in;
         ds_lo_ff   <= ds_lo_in;
         ds_ovf_ff  <= ds_ovf_in;
         ds_neg_ff  <= ds_neg_in;
         ds_len_ff  <= ds_len;
         ds_zero_ff <= ds_len == 32'd0;
         ds_ctl_ff  <= rt_ctl_ff[SQ_STG-1];
      end
   end

   // divide, four lanes, two quotient bits per stage
   logic [31:0] dv_rem_ff  [DV_STG][4];
   logic [31:0] dv_q_ff    [DV_STG][4];
   logic [31:0] dv_lo_ff   [DV_STG][4];
   logic [3:0]  dv_ovf_ff  [DV_STG];
   logic [3:0]  dv_neg_ff  [DV_STG];
   logic [31:0] dv_len_ff  [DV_STG];
   logic        dv_zero_ff [DV_STG];
   ctl_type     dv_ctl_ff  [DV_STG];

   for (genvar gd = 0; gd < DV_STG; gd++) begin : g_dv
      logic [31:0] rem_prev [4];
      logic [31:0] q_prev   [4];
      logic [31:0] lo_prev  [4];
      logic [31:0] len_prev;
      dv_step_type st0 [4];
      dv_step_type st1 [4];

      if (gd == 0) begin : g_first
         assign rem_prev = ds_rem_ff;
         assign q_prev   = '{default: '0};
         assign lo_prev  = ds_lo_ff;
         assign len_prev = ds_len_ff;
      end else begin : g_next
         assign rem_prev = dv_rem_ff[gd-1];
         assign q_prev   = dv_q_ff[gd-1];
         assign lo_prev  = dv_lo_ff[gd-1];
         assign len_prev = dv_len_ff[gd-1];
      end

      always_comb begin
         for (int l = 0; l < 4; l++) begin
            st0[l] = dv_step(rem_prev[l], q_prev[l], lo_prev[l][31-2*gd], len_prev);
            st1[l] = dv_step(st0[l].rem, st0[l].q, lo_prev[l][30-2*gd], len_prev);
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[S_DV0+gd]) begin
            for (int l = 0; l < 4; l++) begin
               dv_rem_ff[gd][l] <= st1[l].rem;
               dv_q_ff[gd][l]   <= st1[l].q;
            end
            dv_lo_ff[gd]  <= lo_prev;
            dv_len_ff[gd] <= len_prev;
            if (gd == 0) begin
               dv_ovf_ff[gd]  <= ds_ovf_ff;
               dv_neg_ff[gd]  <= ds_neg_ff;
               dv_zero_ff[gd] <= ds_zero_ff;
               dv_ctl_ff[gd]  <= ds_ctl_ff;
            end else begin
               dv_ovf_ff[gd]  <= dv_ovf_ff[gd-1];
               dv_neg_ff[gd]  <= dv_neg_ff[gd-1];
               dv_zero_ff[gd] <= dv_zero_ff[gd-1];
               dv_ctl_ff[gd]  <= dv_ctl_ff[gd-1];
            end
         end
      end
   end

   // output stage: sign, saturation and status
   fix_type    out_in [4];
   status_type status_in;

   always_comb begin
      logic [31:0] q;
      logic        ovf;
      for (int l = 0; l < 4; l++) begin
         q   = dv_q_ff[DV_STG-1][l];
         ovf = dv_ovf_ff[DV_STG-1][l];
         if (dv_neg_ff[DV_STG-1][l]) begin
            if (ovf || q > 32'h8000_0000) begin
               out_in[l] = fix_type'(32'h8000_0000);
            end else begin
               out_in[l] = fix_type'(~q + 32'd1);
            end
         end else begin
            if (ovf || q > 32'h7fff_ffff) begin
               out_in[l] = fix_type'(32'h7fff_ffff);
            end else begin
               out_in[l] = fix_type'(q);
            end
         end
      end
      status_in = STAT_OK;
      if (dv_ctl_ff[DV_STG-1].bad) begin
         status_in = STAT_BAD_SEL;
      end else if (dv_zero_ff[DV_STG-1]) begin
         status_in = STAT_ZERO_LEN;
      end
      if (status_in != STAT_OK) begin
         out_in = '{default: '0};
      end
   end

   fix_type    out_plane_ff [4];
   status_type out_status_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_OUT]) begin
         out_plane_ff  <= out_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_plane_a = out_plane_ff[0];
   assign rsp_plane_b = out_plane_ff[1];
   assign rsp_plane_c = out_plane_ff[2];
   assign rsp_plane_d = out_plane_ff[3];
   assign rsp_status  = out_status_ff;

   a_flag_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |->
         rsp_plane_a == 0 && rsp_plane_b == 0 && rsp_plane_c == 0 && rsp_plane_d == 0)
      else $error("flagged beat carries a nonzero plane");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> st_v_ff[S_MUL] && st_v_ff[S_DOT])
      else $error("request stalled while the front of the pipe has room");

endmodule

// ----- bench/frustum_plane_extract_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_plane_extract_tb
// Drives view matrices and plane selectors into the plane extractor under
// several projection settings, with random gaps and random response stalls.
// Every response is compared field by field against a plane computed here
// from the same view matrix and the projection held in the local copy.
// ----------------------------------------------------------------------------
module frustum_plane_extract_tb;
   import fpe_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = 39;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      fix_type    a;
      fix_type    b;
      fix_type    c;
      fix_type    d;
      logic [1:0] status;
   } plane_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [63:0] req_view [8];
   logic        rsp_valid;
   logic        rsp_stall;
   fix_type     rsp_plane_a, rsp_plane_b, rsp_plane_c, rsp_plane_d;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   logic [63:0]    proj_copy [8];
   plane_beat_type pending_planes [$];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          beats_checked = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          cycles = 0;
   int          hold_left = 0;
   bit          hold_start = 0;
   bit          quiet = 0;

   frustum_plane_extract dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_view_r0_c01(req_view[0]), .req_view_r0_c23(req_view[1]),
      .req_view_r1_c01(req_view[2]), .req_view_r1_c23(req_view[3]),
      .req_view_r2_c01(req_view[4]), .req_view_r2_c23(req_view[5]),
      .req_view_r3_c01(req_view[6]), .req_view_r3_c23(req_view[7]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_plane_a(rsp_plane_a), .rsp_plane_b(rsp_plane_b),
      .rsp_plane_c(rsp_plane_c), .rsp_plane_d(rsp_plane_d), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic fix_type sat_fix(input logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'h7fffffff;
      if (v < -68'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic fix_type scale_unit(input fix_type x, input longint unsigned len);
      longint unsigned mag, q;
      mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
      q = ((mag << FB) + len / 2) / len;
      if (x < 0) return (q > 64'h80000000) ? 32'h80000000 : fix_type'(-longint'(q));
      return (q > 64'h7fffffff) ? 32'h7fffffff : fix_type'(q);
   endfunction

   function automatic fix_type elem(input logic [63:0] rows [8], input int r, input int c);
      logic [63:0] w;
      w = rows[2 * r + c / 2];
      return (c % 2) ? w[63:32] : w[31:0];
   endfunction

   function automatic plane_beat_type extract_plane(input logic [2:0] sel,
                                                    input logic [63:0] view [8]);
      plane_beat_type     res;
      fix_type            m [4][4];
      fix_type            t [4];
      logic signed [67:0] acc;
      longint             prod;
      longint unsigned    sq, len;
      int                 col;
      bit                 neg, near_pl;
      res = '{0, 0, 0, 0, STAT_OK};
      neg = 0;
      near_pl = 0;
      case (sel)
         PLANE_LEFT: col = 0;
         PLANE_RIGHT: begin col = 0; neg = 1; end
         PLANE_TOP: begin col = 1; neg = 1; end
         PLANE_BOTTOM: col = 1;
         PLANE_NEAR: begin col = 2; near_pl = 1; end
         PLANE_FAR: begin col = 2; neg = 1; end
         default: begin
            res.status = STAT_BAD_SEL;
            return res;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
               prod = longint'(elem(view, i, k)) * longint'(elem(proj_copy, k, j));
               acc += prod;
            end
            m[i][j] = sat_fix((acc + (68'sd1 << (FB - 1))) >>> FB);
         end
      end
      for (int i = 0; i < 4; i++) begin
         acc = near_pl ? 68'sd0 : 68'(m[i][3]);
         acc = neg ? acc - 68'(m[i][col]) : acc + 68'(m[i][col]);
         t[i] = sat_fix(acc);
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += longint'(t[i]) * longint'(t[i]);
      len = int_sqrt(sq);
      if (len == 0) begin
         res.status = STAT_ZERO_LEN;
         return res;
      end
      res.a = scale_unit(t[0], len);
      res.b = scale_unit(t[1], len);
      res.c = scale_unit(t[2], len);
      res.d = scale_unit(t[3], len);
      return res;
   endfunction

   // response side: random stalls, long holds on request
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = 400;
         hold_start = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   always @(posedge clock) begin
      plane_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_planes.size() == 0) begin
            $error("response beat with nothing pending");
            mismatches++;
         end else begin
            want = pending_planes.pop_front();
            beats_checked++;
            status_seen[rsp_status]++;
            if (rsp_plane_a !== want.a) begin
               $error("plane_a expected %0d got %0d", want.a, rsp_plane_a);
               mismatches++;
            end
            if (rsp_plane_b !== want.b) begin
               $error("plane_b expected %0d got %0d", want.b, rsp_plane_b);
               mismatches++;
            end
            if (rsp_plane_c !== want.c) begin
               $error("plane_c expected %0d got %0d", want.c, rsp_plane_c);
               mismatches++;
            end
            if (rsp_plane_d !== want.d) begin
               $error("plane_d expected %0d got %0d", want.d, rsp_plane_d);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_plane(input logic [2:0] sel, input logic [63:0] view [8]);
      int gap, r;
      r = $urandom_range(0, 99);
      gap = quiet ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= sel;
      for (int i = 0; i < 8; i++) req_view[i] <= view[i];
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_planes.push_back(extract_plane(sel, view));
      beats_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_planes.size() > 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic load_proj(input logic [63:0] rows [8]);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= rows[i];
         forever begin
            @(posedge clock);
            if (csr_ready) break;
         end
         proj_copy[i] = rows[i];
      end
      csr_valid <= 1'b0;
   endtask

   function automatic fix_type rand_fix(input int mode);
      case (mode)
         0: return $urandom;
         1: return fix_type'($urandom_range(0, 32'h5ffff)) - 32'sh30000;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h0;
               1: return 32'h00010000;
               2: return 32'hffff0000;
               3: return 32'h7fffffff;
               default: return 32'h80000000;
            endcase
         end
      endcase
   endfunction

   task automatic rand_matrix(output logic [63:0] rows [8]);
      int r, mode;
      r = $urandom_range(0, 99);
      mode = (r < 70) ? 1 : (r < 90) ? 0 : 2;
      for (int i = 0; i < 8; i++) rows[i] = {rand_fix(mode), rand_fix(mode)};
      if ($urandom_range(0, 49) == 0) begin
         for (int i = 0; i < 8; i++) rows[i] = 64'h0;
      end
   endtask

   function automatic logic [2:0] rand_sel();
      return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
   endfunction

   task automatic test_reset_proj();
      logic [63:0] v [8];
      for (int s = 0; s < 8; s++) begin
         rand_matrix(v);
         send_plane(s[2:0], v);
      end
      wait_drain();
   endtask

   task automatic test_directed();
      logic [63:0] p [8];
      logic [63:0] v [8];
      p = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
            64'h0, 64'hffff_0000_fffe_0000, 64'h0, 64'h0000_0000_ffff_c000};
      load_proj(p);
      v = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
            64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};
      for (int s = 0; s < 8; s++) send_plane(s[2:0], v);
      for (int i = 0; i < 8; i++) v[i] = 64'h0;
      send_plane(PLANE_LEFT, v);
      send_plane(PLANE_NEAR, v);
      for (int i = 0; i < 8; i++) v[i] = 64'h7fffffff_7fffffff;
      send_plane(PLANE_RIGHT, v);
      send_plane(PLANE_FAR, v);
      for (int i = 0; i < 8; i++) v[i] = 64'h80000000_80000000;
      send_plane(PLANE_TOP, v);
      send_plane(PLANE_BOTTOM, v);
      for (int i = 0; i < 8; i++) v[i] = 64'hffffffff_ffffffff;
      send_plane(PLANE_NEAR, v);
      wait_drain();
      for (int i = 0; i < 8; i++) p[i] = 64'h7fffffff_7fffffff;
      load_proj(p);
      for (int i = 0; i < 8; i++) v[i] = 64'h80000000_7fffffff;
      for (int s = 0; s < 6; s++) send_plane(s[2:0], v);
      wait_drain();
   endtask

   task automatic test_random_phase(input int mode, input int count);
      logic [63:0] p [8];
      logic [63:0] v [8];
      for (int i = 0; i < 8; i++) p[i] = {rand_fix(mode), rand_fix(mode)};
      load_proj(p);
      for (int n = 0; n < count; n++) begin
         quiet = (n % 100) >= 80;
         rand_matrix(v);
         send_plane(rand_sel(), v);
      end
      quiet = 0;
      wait_drain();
   endtask

   task automatic test_backpressure();
      logic [63:0] v [8];
      hold_start = 1;
      quiet = 1;
      for (int n = 0; n < 150; n++) begin
         rand_matrix(v);
         send_plane(rand_sel(), v);
      end
      quiet = 0;
      wait_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      for (int i = 0; i < 8; i++) req_view[i] = '0;
      for (int i = 0; i < 8; i++) proj_copy[i] = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_stall = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_proj();
      test_directed();
      test_random_phase(1, 300);
      test_random_phase(0, 200);
      test_random_phase(1, 250);
      test_random_phase(2, 120);
      test_backpressure();
      $display("sent %0d requests over seven projection settings, checked %0d responses",
               beats_sent, beats_checked);
      $display("status counts: ok %0d, bad selector %0d, zero normal %0d",
               status_seen[0], status_seen[1], status_seen[2]);
      if (mismatches == 0 && pending_planes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
